// ===== hw/rtl/srwg_pkg.sv =====
// Package for the sequence resequencing block: window size, codes and the
// result record shared by the sequencer and its output stage.
// No dependencies.
`default_nettype none

package srwg_pkg;

   // Window slots; a power of two, so a slot is the low bits of a sequence.
   localparam int WINDOW    = 16;
   localparam int SLOT_BITS = $clog2(WINDOW);
   localparam int SEQ_W     = 32;
   localparam int DATA_W    = 32;
   localparam int CNT_W     = 8;

   // Input item kinds
   localparam logic [1:0] ACT_DATA     = 2'd0;
   localparam logic [1:0] ACT_HEARTBEAT = 2'd1;
   localparam logic [1:0] ACT_SHUTDOWN = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_DATA     = 2'd0;
   localparam logic [1:0] KIND_GAP      = 2'd1;
   localparam logic [1:0] KIND_HEARTBEAT = 2'd2;
   localparam logic [1:0] KIND_SHUTDOWN = 2'd3;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef struct packed {
      logic [1:0]        kind;
      logic [SEQ_W-1:0]  out_sequence;
      logic [SEQ_W-1:0]  gap_first;
      logic [SEQ_W-1:0]  gap_last;
      logic [DATA_W-1:0] out_payload;
   } result_type;

   typedef struct packed {
      logic can_emit;
      logic hold_valid;
   } out_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/srwg_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module srwg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/srwg_out.sv =====
// Result staging: a hold register that keeps the newest result until the
// next one (or the end of the item) decides its last flag, then the output.
// Depends on srwg_pkg.
`default_nettype none

module srwg_out (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   emit_valid,
   input  wire srwg_pkg::result_type   emit_res,
   input  wire logic                   finish,
   output srwg_pkg::out_status_type    status,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output srwg_pkg::result_type        rsp_res,
   output logic                        rsp_last
);

   logic                 hold_valid_ff, hold_valid_in;
   srwg_pkg::result_type hold_ff, hold_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   srwg_pkg::result_type rsp_res_ff, rsp_res_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 out_free;
   logic                 can_emit;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign can_emit = !hold_valid_ff || out_free;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_res_in    = rsp_res_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit_valid && can_emit) begin
         if (hold_valid_ff) begin
            rsp_res_in   = hold_ff;
            rsp_last_in  = 1'b0;
            rsp_valid_in = 1'b1;
         end
         hold_in       = emit_res;
         hold_valid_in = 1'b1;
      end else if (finish && can_emit && hold_valid_ff) begin
         rsp_res_in    = hold_ff;
         rsp_last_in   = 1'b1;
         rsp_valid_in  = 1'b1;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      hold_ff     <= hold_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.can_emit   = can_emit;
   assign status.hold_valid = hold_valid_ff;
   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_res           = rsp_res_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sequence_reorder_with_gaps.sv =====
// Sequence resequencing buffer with gap detection, top level.
// Depends on srwg_pkg, srwg_ram and srwg_out.
//
// Usage:
//   req_* carries one item: data (sequence, payload), heartbeat or shutdown.
//   rsp_* carries results: data, gap reports, forwarded heartbeat/shutdown;
//   rsp_tlast marks the final result caused by one item.
//   csr_wr_en/csr_wr_data write the heartbeat delay limit (reset value 1).
// Flow: one item at a time. An in-order data item passes the states DATA,
//   EMIT_IN, RUN and FINISH; a stashed or dropped one only DATA and FINISH.
//   Each released stashed message adds a flag test and a payload RAM read,
//   and each gap search walks the window one slot a cycle, up to WINDOW
//   slots per search.
// Path: an in-order data item reaches rsp through the hold register and then
//   the output register. Each result waits in the hold register until the
//   next result or the end of the item settles its last flag.
// Reset: synchronous; clears all slot flags and counters at once, no sweep.
// Stall: when rsp_tready is low, the sequencer waits in each state that emits
//   or finishes once the hold and output registers are both full; req_tready stays low until done.
`default_nettype none

module sequence_reorder_with_gaps (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,   // sequence_req[31:0], payload[63:32]
   input  wire logic [1:0]   req_tuser,   // action
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,   // out_sequence, gap_first, gap_last, out_payload
   output logic [1:0]        rsp_tuser,   // kind
   output logic              rsp_tlast,   // last
   input  wire logic         csr_wr_en,
   input  wire logic [7:0]   csr_wr_data  // heartbeat delay limit
);

   localparam int SB = srwg_pkg::SLOT_BITS;
   localparam int SW = srwg_pkg::SEQ_W;

   typedef enum logic [3:0] {
      S_IDLE, S_DATA, S_FAR_CHECK, S_EMIT_IN, S_FAR_GAP, S_FAR_DATA,
      S_SCAN, S_RUN, S_RUN_RD, S_HB, S_HB_LOOP, S_HB_END, S_HB_OUT,
      S_SD_LOOP, S_SD_END, S_FINISH
   } state_type;

   typedef enum logic [1:0] {CTX_DONE, CTX_FAR, CTX_HB, CTX_SD} ctx_type;

   state_type                      state_ff, state_in;
   ctx_type                        ctx_ff, ctx_in;
   logic [SW-1:0]                  seq_ff, seq_in;
   logic [srwg_pkg::DATA_W-1:0]    pl_ff, pl_in;
   logic [SW-1:0]                  ne_ff, ne_in;
   logic [SW-1:0]                  hs_ff, hs_in;
   logic [SW-1:0]                  be_ff, be_in;
   logic [SW-1:0]                  bh_ff, bh_in;
   logic [srwg_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [srwg_pkg::CNT_W-1:0]     max_ff, max_in;
   logic [SB-1:0]                  k_ff, k_in;
   logic [srwg_pkg::WINDOW-1:0]    full_ff, full_in;

   logic [SW-1:0]                  ne_eff, hs_eff, diff, far_diff, gap_end;
   logic [srwg_pkg::CNT_W-1:0]     cnt_next;
   logic [SB-1:0]                  scan_slot, ne_slot, seq_slot;
   logic                           emit, finish;
   srwg_pkg::result_type           emit_res;
   srwg_pkg::out_status_type       ostat;
   srwg_pkg::result_type           rsp_res;
   logic                           ram_wr_en, ram_rd_en;
   logic [srwg_pkg::DATA_W-1:0]    ram_rd_data;
   logic                           accept;

   assign accept    = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   assign ne_eff    = (ne_ff == '0) ? seq_ff : ne_ff;
   assign hs_eff    = (ne_ff == '0) ? seq_ff : hs_ff;
   assign diff      = seq_ff - ne_eff;
   assign far_diff  = seq_ff - ne_ff;
   assign ne_slot   = ne_ff[SB-1:0];
   assign seq_slot  = seq_ff[SB-1:0];
   assign scan_slot = ne_slot + k_ff;
   assign gap_end   = ne_ff + SW'(k_ff);
   assign cnt_next  = (cnt_ff == srwg_pkg::CNT_MAX) ? cnt_ff : cnt_ff + 1'b1;

   always_comb begin
      state_in  = state_ff;
      ctx_in    = ctx_ff;
      seq_in    = seq_ff;
      pl_in     = pl_ff;
      ne_in     = ne_ff;
      hs_in     = hs_ff;
      be_in     = be_ff;
      bh_in     = bh_ff;
      cnt_in    = cnt_ff;
      max_in    = csr_wr_en ? csr_wr_data : max_ff;
      k_in      = k_ff;
      full_in   = full_ff;
      emit      = 1'b0;
      finish    = 1'b0;
      emit_res  = '0;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               seq_in = req_tdata[31:0];
               pl_in  = req_tdata[63:32];
               unique case (req_tuser)
                  srwg_pkg::ACT_DATA:      state_in = S_DATA;
                  srwg_pkg::ACT_HEARTBEAT: state_in = S_HB;
                  srwg_pkg::ACT_SHUTDOWN: begin
                     ctx_in   = CTX_SD;
                     state_in = S_SD_LOOP;
                  end
                  default:                 state_in = S_FINISH;
               endcase
            end
         end
         S_DATA: begin
            ne_in = ne_eff;
            hs_in = hs_eff;
            if (seq_ff == ne_eff) begin
               state_in = S_EMIT_IN;
            end else if (seq_ff < ne_eff) begin
               state_in = S_FINISH;           // old item, dropped
            end else if (diff < SW'(srwg_pkg::WINDOW)) begin
               if (!full_ff[seq_slot]) begin
                  ram_wr_en          = 1'b1;
                  full_in[seq_slot]  = 1'b1;
                  if (seq_ff > hs_eff) hs_in = seq_ff;
               end
               state_in = S_FINISH;
            end else begin
               ctx_in   = CTX_FAR;
               state_in = S_FAR_CHECK;
            end
         end
         S_FAR_CHECK: begin
            if (ne_ff < seq_ff && far_diff >= SW'(srwg_pkg::WINDOW)) begin
               k_in     = '0;
               state_in = S_SCAN;
            end else begin
               hs_in = seq_ff;
               if (seq_ff == ne_ff) begin
                  state_in = S_EMIT_IN;
               end else begin
                  if (!full_ff[seq_slot]) begin
                     ram_wr_en         = 1'b1;
                     full_in[seq_slot] = 1'b1;
                  end
                  state_in = S_FINISH;
               end
            end
         end
         S_EMIT_IN: begin
            emit                  = 1'b1;
            emit_res.kind         = srwg_pkg::KIND_DATA;
            emit_res.out_sequence = seq_ff;
            emit_res.out_payload  = pl_ff;
            if (ostat.can_emit) begin
               ne_in    = ne_ff + 1'b1;
               ctx_in   = CTX_DONE;
               state_in = S_RUN;
            end
         end
         S_FAR_GAP: begin
            // nothing stashed: one gap up to the item, which is then sent
            emit                  = 1'b1;
            emit_res.kind         = srwg_pkg::KIND_GAP;
            emit_res.out_sequence = seq_ff;
            emit_res.gap_first    = ne_ff;
            emit_res.gap_last     = seq_ff - 1'b1;
            if (ostat.can_emit) state_in = S_FAR_DATA;
         end
         S_FAR_DATA: begin
            emit                  = 1'b1;
            emit_res.kind         = srwg_pkg::KIND_DATA;
            emit_res.out_sequence = seq_ff;
            emit_res.out_payload  = pl_ff;
            if (ostat.can_emit) begin
               ne_in    = seq_ff + 1'b1;
               hs_in    = seq_ff;
               state_in = S_FINISH;
            end
         end
         S_SCAN: begin
            // walk the window for the first stashed slot at or after ne
            if (full_ff[scan_slot]) begin
               if (k_ff == '0) begin
                  state_in = S_RUN;
               end else begin
                  emit                  = 1'b1;
                  emit_res.kind         = srwg_pkg::KIND_GAP;
                  emit_res.out_sequence = gap_end;
                  emit_res.gap_first    = ne_ff;
                  emit_res.gap_last     = gap_end - 1'b1;
                  if (ostat.can_emit) begin
                     ne_in    = gap_end;
                     state_in = S_RUN;
                  end
               end
            end else if (k_ff == SB'(srwg_pkg::WINDOW - 1)) begin
               unique case (ctx_ff)
                  CTX_FAR: state_in = S_FAR_GAP;
                  CTX_HB:  state_in = S_HB_END;
                  CTX_SD:  state_in = S_SD_END;
                  CTX_DONE: state_in = S_FINISH;
               endcase
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_RUN: begin
            if (full_ff[ne_slot]) begin
               ram_rd_en = 1'b1;
               state_in  = S_RUN_RD;
            end else begin
               unique case (ctx_ff)
                  CTX_DONE: state_in = S_FINISH;
                  CTX_FAR:  state_in = S_FAR_CHECK;
                  CTX_HB:   state_in = S_HB_LOOP;
                  CTX_SD:   state_in = S_SD_LOOP;
               endcase
            end
         end
         S_RUN_RD: begin
            emit                  = 1'b1;
            emit_res.kind         = srwg_pkg::KIND_DATA;
            emit_res.out_sequence = ne_ff;
            emit_res.out_payload  = ram_rd_data;
            if (ostat.can_emit) begin
               full_in[ne_slot] = 1'b0;
               ne_in            = ne_ff + 1'b1;
               state_in         = S_RUN;
            end
         end
         S_HB: begin
            if (ne_ff == be_ff) begin
               cnt_in = cnt_next;
               if (cnt_next >= max_ff) begin
                  ctx_in   = CTX_HB;
                  state_in = S_HB_LOOP;
               end else begin
                  state_in = S_HB_OUT;
               end
            end else begin
               state_in = S_HB_END;
            end
         end
         S_HB_LOOP: begin
            if (ne_ff < bh_ff) begin
               k_in     = '0;
               state_in = S_SCAN;
            end else begin
               state_in = S_HB_END;
            end
         end
         S_HB_END: begin
            be_in    = ne_ff;
            bh_in    = hs_ff;
            cnt_in   = '0;
            state_in = S_HB_OUT;
         end
         S_HB_OUT: begin
            emit          = 1'b1;
            emit_res.kind = srwg_pkg::KIND_HEARTBEAT;
            if (ostat.can_emit) state_in = S_FINISH;
         end
         S_SD_LOOP: begin
            k_in     = '0;
            state_in = S_SCAN;
         end
         S_SD_END: begin
            emit          = 1'b1;
            emit_res.kind = srwg_pkg::KIND_SHUTDOWN;
            if (ostat.can_emit) state_in = S_FINISH;
         end
         S_FINISH: begin
            finish = 1'b1;
            if (ostat.can_emit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ctx_ff   <= CTX_DONE;
         ne_ff    <= '0;
         hs_ff    <= '0;
         be_ff    <= '0;
         bh_ff    <= '0;
         cnt_ff   <= '0;
         max_ff   <= srwg_pkg::CNT_W'(1);
         k_ff     <= '0;
         full_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ctx_ff   <= ctx_in;
         ne_ff    <= ne_in;
         hs_ff    <= hs_in;
         be_ff    <= be_in;
         bh_ff    <= bh_in;
         cnt_ff   <= cnt_in;
         max_ff   <= max_in;
         k_ff     <= k_in;
         full_ff  <= full_in;
      end
      seq_ff <= seq_in;
      pl_ff  <= pl_in;
   end

   srwg_ram #(
      .WIDTH (srwg_pkg::DATA_W),
      .DEPTH (srwg_pkg::WINDOW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (seq_slot),
      .wr_data (pl_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ne_slot),
      .rd_data (ram_rd_data)
   );

   srwg_out u_out (
      .clock      (clock),
      .reset      (reset),
      .emit_valid (emit),
      .emit_res   (emit_res),
      .finish     (finish),
      .status     (ostat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {rsp_res.out_payload, rsp_res.gap_last,
                       rsp_res.gap_first, rsp_res.out_sequence};
   assign rsp_tuser = rsp_res.kind;

   // the payload read state is only entered from the flag test (or held while stalled)
   a_rd_after_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RUN_RD |-> $past(state_ff) == S_RUN || $past(state_ff) == S_RUN_RD)
      else $error("payload read without flag test");

   // the slot being released must still be marked full
   a_rd_slot_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RUN_RD |-> full_ff[ne_slot])
      else $error("release from empty slot");

   // every result of an item has left the hold register before the next is taken
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !ostat.hold_valid)
      else $error("result held across items");

   // a stash write never lands on a slot already full
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> !full_ff[seq_slot])
      else $error("stash overwrite");

endmodule

`default_nettype wire

// ===== verif/srwg_checker.sv =====
// Checker for sequence_reorder_with_gaps: watches the req, rsp and csr ports,
// predicts every result item and compares it field by field in order.
// Depends on srwg_pkg.
`timescale 1ns / 1ps

module srwg_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [63:0]  req_tdata,
   input  wire logic [1:0]   req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [127:0] rsp_tdata,
   input  wire logic [1:0]   rsp_tuser,
   input  wire logic         rsp_tlast,
   input  wire logic         csr_wr_en,
   input  wire logic [7:0]   csr_wr_data,
   output int                fail_count,
   output int                pending,
   output int                result_count
);

   localparam int MAX_RESULTS = 40;
   localparam int SW = srwg_pkg::SEQ_W;
   localparam int DW = srwg_pkg::DATA_W;

   typedef struct {
      srwg_pkg::result_type r;
      logic                 last;
   } reorder_result_type;

   reorder_result_type expected_results[$];
   reorder_result_type item_results[$];

   logic [DW-1:0]               stash_payload [srwg_pkg::WINDOW];
   logic                        stash_full [srwg_pkg::WINDOW];
   logic [SW-1:0]               next_seq, top_stashed, beat_seq, beat_top;
   logic [srwg_pkg::CNT_W-1:0]  stall_beats, max_beats;

   function automatic int slot(logic [SW-1:0] s);
      return int'(s[srwg_pkg::SLOT_BITS-1:0]);
   endfunction

   function automatic void add_result(logic [1:0] k, logic [SW-1:0] s,
                                      logic [SW-1:0] gf, logic [SW-1:0] gl,
                                      logic [DW-1:0] pl);
      reorder_result_type e;
      if (item_results.size() >= MAX_RESULTS) return;
      e.r.kind = k;
      e.r.out_sequence = s;
      e.r.gap_first = gf;
      e.r.gap_last = gl;
      e.r.out_payload = pl;
      e.last = 1'b0;
      item_results.push_back(e);
   endfunction

   function automatic void drain_run();
      while (stash_full[slot(next_seq)]) begin
         add_result(srwg_pkg::KIND_DATA, next_seq, '0, '0, stash_payload[slot(next_seq)]);
         stash_full[slot(next_seq)] = 1'b0;
         next_seq++;
      end
   endfunction

   // Skip to the nearest stashed entry, reporting the hole; 0 if stash is empty
   function automatic bit skip_gap();
      logic [SW-1:0] start, stop;
      start = next_seq;
      if (stash_full[slot(start)]) return 1'b1;
      for (int k = 1; k < srwg_pkg::WINDOW; k++) begin
         stop = start + SW'(k);
         if (stash_full[slot(stop)]) begin
            add_result(srwg_pkg::KIND_GAP, stop, start, stop - 1, '0);
            next_seq = stop;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void predict_data(logic [SW-1:0] s, logic [DW-1:0] pl);
      if (next_seq == 0) begin
         next_seq = s;
         top_stashed = s;
      end
      if (s == next_seq) begin
         add_result(srwg_pkg::KIND_DATA, s, '0, '0, pl);
         next_seq++;
         drain_run();
      end else if (s < next_seq) begin
         // stale, dropped
      end else if (s - next_seq < srwg_pkg::WINDOW) begin
         if (!stash_full[slot(s)]) begin
            stash_payload[slot(s)] = pl;
            stash_full[slot(s)] = 1'b1;
            if (s > top_stashed) top_stashed = s;
         end
      end else begin
         while (next_seq < s && s - next_seq >= srwg_pkg::WINDOW) begin
            if (skip_gap()) begin
               drain_run();
            end else begin
               // far future over an empty stash: one gap, then the item itself
               add_result(srwg_pkg::KIND_GAP, s, next_seq, s - 1, '0);
               add_result(srwg_pkg::KIND_DATA, s, '0, '0, pl);
               next_seq = s + 1;
               top_stashed = s;
               return;
            end
         end
         top_stashed = s;
         if (s == next_seq) begin
            add_result(srwg_pkg::KIND_DATA, s, '0, '0, pl);
            next_seq++;
            drain_run();
         end else if (!stash_full[slot(s)]) begin
            stash_payload[slot(s)] = pl;
            stash_full[slot(s)] = 1'b1;
         end
      end
   endfunction

   function automatic void predict_heartbeat();
      if (next_seq == beat_seq) begin
         if (stall_beats != srwg_pkg::CNT_MAX) stall_beats++;
         if (stall_beats >= max_beats) begin
            while (next_seq < beat_top && skip_gap()) drain_run();
            beat_seq = next_seq;
            beat_top = top_stashed;
            stall_beats = '0;
         end
      end else begin
         beat_seq = next_seq;
         beat_top = top_stashed;
         stall_beats = '0;
      end
      add_result(srwg_pkg::KIND_HEARTBEAT, '0, '0, '0, '0);
   endfunction

   function automatic void predict_item(logic [1:0] act, logic [SW-1:0] s,
                                        logic [DW-1:0] pl);
      item_results.delete();
      case (act)
         srwg_pkg::ACT_DATA: predict_data(s, pl);
         srwg_pkg::ACT_HEARTBEAT: predict_heartbeat();
         srwg_pkg::ACT_SHUTDOWN: begin
            while (skip_gap()) drain_run();
            add_result(srwg_pkg::KIND_SHUTDOWN, '0, '0, '0, '0);
         end
         default: ;
      endcase
      if (item_results.size() > 0) item_results[item_results.size()-1].last = 1'b1;
      foreach (item_results[i]) expected_results.push_back(item_results[i]);
   endfunction

   always @(posedge clock) begin
      reorder_result_type e;
      srwg_pkg::result_type got;
      if (reset) begin
         foreach (stash_full[i]) stash_full[i] = 1'b0;
         next_seq = '0; top_stashed = '0; beat_seq = '0; beat_top = '0;
         stall_beats = '0; max_beats = 8'd1;
         expected_results.delete();
         fail_count = 0;
         result_count = 0;
      end else begin
         if (csr_wr_en) max_beats = csr_wr_data;
         if (req_tvalid && req_tready)
            predict_item(req_tuser, req_tdata[31:0], req_tdata[63:32]);
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.out_sequence = rsp_tdata[31:0];
            got.gap_first = rsp_tdata[63:32];
            got.gap_last = rsp_tdata[95:64];
            got.out_payload = rsp_tdata[127:96];
            result_count++;
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: kind %0d seq %h gap %h..%h pl %h last %b",
                           got.kind, got.out_sequence, got.gap_first, got.gap_last,
                           got.out_payload, rsp_tlast);
            end else begin
               e = expected_results.pop_front();
               if (got !== e.r || rsp_tlast !== e.last) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch at result %0d:", result_count);
                     $display("  exp kind %0d seq %h gap %h..%h pl %h last %b",
                              e.r.kind, e.r.out_sequence, e.r.gap_first, e.r.gap_last,
                              e.r.out_payload, e.last);
                     $display("  got kind %0d seq %h gap %h..%h pl %h last %b",
                              got.kind, got.out_sequence, got.gap_first, got.gap_last,
                              got.out_payload, rsp_tlast);
                  end
               end
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

// ===== verif/tb_top.sv =====
// Top of the sequence_reorder_with_gaps testbench: clock, reset, stimulus,
// receiver backpressure and verdict. Depends on srwg_pkg and srwg_checker.
`timescale 1ns / 1ps

module tb_top;

   // item kind the block ignores
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;
   logic [1:0]   req_tuser = srwg_pkg::ACT_DATA;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_wr_en = 1'b0;
   logic [7:0]   csr_wr_data = '0;

   int fail_count, pending, result_count;
   int send_idle_pct = 21, recv_idle_pct = 49;
   int items_sent = 0, cycle_count = 0;
   logic [31:0] seq_base;

   sequence_reorder_with_gaps dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   srwg_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending(pending), .result_count(result_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 600000) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
         $display("[sequence_reorder_with_gaps] ERROR");
         $finish;
      end
   end

   // Called at a rising edge; returns at the edge that accepts the item.
   task automatic send(logic [1:0] act, logic [31:0] s, logic [31:0] pl);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {pl, s};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      items_sent++;
   endtask

   // Stashed items produce nothing, so allow the block to settle past the queue.
   task automatic write_max_delay(logic [7:0] v);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_items(int n);
      int pick;
      logic [31:0] s;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            s = seq_base + $urandom_range(0, 6);
            if ($urandom_range(2) == 0) seq_base++;
            send(srwg_pkg::ACT_DATA, s, $urandom);
         end else if (pick < 60) begin
            s = seq_base + $urandom_range(16, 40);
            send(srwg_pkg::ACT_DATA, s, $urandom);
            if ($urandom_range(1) == 0) seq_base = s - $urandom_range(0, 8);
         end else if (pick < 68) begin
            send(srwg_pkg::ACT_DATA, seq_base - $urandom_range(1, 20), $urandom);
         end else if (pick < 72) begin
            seq_base = $urandom;
            send(srwg_pkg::ACT_DATA, seq_base, $urandom);
         end else if (pick < 88) begin
            send(srwg_pkg::ACT_HEARTBEAT, $urandom, $urandom);
         end else if (pick < 95) begin
            send(srwg_pkg::ACT_SHUTDOWN, $urandom, $urandom);
         end else begin
            send(ACT_UNUSED, $urandom, $urandom);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: ordering, stash, duplicates, stale, far future, flushes, wrap
      write_max_delay(8'd1);
      send(srwg_pkg::ACT_DATA, 32'd100, 32'h0000_0000);
      send(srwg_pkg::ACT_DATA, 32'd102, 32'hFFFF_FFFF);
      send(srwg_pkg::ACT_DATA, 32'd102, 32'h1234_5678);
      send(srwg_pkg::ACT_DATA, 32'd101, 32'hA5A5_A5A5);
      send(srwg_pkg::ACT_DATA, 32'd99, 32'h5A5A_5A5A);
      send(srwg_pkg::ACT_DATA, 32'd106, 32'h0000_0106);
      send(srwg_pkg::ACT_DATA, 32'd109, 32'h0000_0109);
      send(srwg_pkg::ACT_HEARTBEAT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(srwg_pkg::ACT_HEARTBEAT, 32'd0, 32'd0);
      send(srwg_pkg::ACT_DATA, 32'd112, 32'h0000_0112);
      send(srwg_pkg::ACT_DATA, 32'd150, 32'h0000_0150);
      send(srwg_pkg::ACT_DATA, 32'd400, 32'h0000_0400);
      send(srwg_pkg::ACT_DATA, 32'd405, 32'h0000_0405);
      send(srwg_pkg::ACT_SHUTDOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(srwg_pkg::ACT_DATA, 32'hFFFF_FFFE, 32'hDEAD_BEEF);
      send(srwg_pkg::ACT_DATA, 32'hFFFF_FFFF, 32'h0BAD_F00D);
      send(srwg_pkg::ACT_DATA, 32'd5, 32'h0000_0005);
      send(srwg_pkg::ACT_DATA, 32'd7, 32'h0000_0007);
      send(srwg_pkg::ACT_SHUTDOWN, 32'd0, 32'd0);
      send(srwg_pkg::ACT_DATA, 32'h8000_0000, 32'hFFFF_FFFF);
      seq_base = 32'h8000_0001;

      write_max_delay(8'd0);
      random_items(63);
      send_idle_pct = 49; recv_idle_pct = 21;
      write_max_delay(8'd255);
      random_items(63);
      send_idle_pct = 0; recv_idle_pct = 0;
      write_max_delay(8'($urandom_range(2, 4)));
      seq_base = 32'hFFFF_FFF0;
      random_items(63);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("%0d input items (data, heartbeat, shutdown, unused kind) over 4 delay settings,",
               items_sent);
      $display("%0d result items checked, %0d mismatches", result_count, fail_count);
      if (fail_count == 0 && pending == 0)
         $display("[sequence_reorder_with_gaps] OK");
      else
         $display("[sequence_reorder_with_gaps] ERROR");
      $finish;
   end

endmodule

// ===== sequence_reorder_with_gaps.f =====
hw/rtl/srwg_pkg.sv
hw/rtl/srwg_ram.sv
hw/rtl/srwg_out.sv
hw/rtl/sequence_reorder_with_gaps.sv
verif/srwg_checker.sv
verif/tb_top.sv
